// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/psl_pkg.sv -----
package psl_pkg;

	// table geometry
	localparam int NUM_SYMBOLS = 64;
	localparam int PRICE_BITS  = 32;
	localparam int IDX_W       = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

	// front to back queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// request op codes
	localparam logic [2:0] OP_SET_FIXED = 3'd0;
	localparam logic [2:0] OP_SET_TRAIL = 3'd1;
	localparam logic [2:0] OP_SET_PCT   = 3'd2;
	localparam logic [2:0] OP_REMOVE    = 3'd3;
	localparam logic [2:0] OP_UPDATE    = 3'd4;

	typedef logic [PRICE_BITS-1:0]      price_t;
	typedef logic signed [PRICE_BITS:0] level_t;
	typedef logic [IDX_W-1:0]           idx_t;

	typedef enum logic [1:0] {
		KIND_FIXED = 2'd0,
		KIND_TRAIL = 2'd1,
		KIND_PCT   = 2'd2
	} stop_kind_t;

	// request class decided by the front end
	typedef enum logic [2:0] {
		CLS_IGNORE,
		CLS_SET_FIXED,
		CLS_SET_TRAIL,
		CLS_SET_PCT,
		CLS_REMOVE,
		CLS_UPDATE
	} item_class_t;

	// classified request as it waits in the queue
	typedef struct packed {
		item_class_t cls;
		idx_t        idx;
		price_t      price;
		price_t      trail;
		logic [15:0] frac;
		price_t      avg;
		logic        exit_req;
		logic        exit_side;
		logic [31:0] exit_qty;
	} queue_item_t;

	// one stop table entry
	typedef struct packed {
		stop_kind_t  kind;
		level_t      level;
		price_t      peak;
		price_t      trail;
		logic [15:0] frac;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		B_IDLE,
		B_EVAL,
		B_DONE
	} back_state_t;

endpackage

// ----- rtl/core/psl_ram.sv -----
module psl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/core/psl_front.sv -----
`include "assert_macros.svh"

module psl_front
	import psl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic [5:0]         symbol,
	input  logic [31:0]        price,
	input  logic [31:0]        trail_gap,
	input  logic [15:0]        loss_fraction,
	input  logic [31:0]        basis_price,
	input  logic signed [31:0] position_qty,
	output logic               q_valid,
	output queue_item_t        q_item,
	input  logic               q_pop
);

	queue_item_t        cls_item;
	queue_item_t        q_mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               sym_ok;
	logic [31:0]        qbits;

	// classify the request and precompute the exit side and size
	always_comb begin
		sym_ok = (32'(symbol) < 32'(NUM_SYMBOLS));
		qbits  = position_qty;
		cls_item           = '0;
		cls_item.idx       = idx_t'(symbol);
		cls_item.price     = price_t'(price);
		cls_item.trail     = price_t'(trail_gap);
		cls_item.frac      = loss_fraction;
		cls_item.avg       = price_t'(basis_price);
		cls_item.exit_req  = |qbits;
		cls_item.exit_side = qbits[31];
		cls_item.exit_qty  = qbits[31] ? (32'd0 - qbits) : qbits;
		case (op)
			OP_SET_FIXED: cls_item.cls = CLS_SET_FIXED;
			OP_SET_TRAIL: cls_item.cls = CLS_SET_TRAIL;
			OP_SET_PCT:   cls_item.cls = CLS_SET_PCT;
			OP_REMOVE:    cls_item.cls = CLS_REMOVE;
			OP_UPDATE:    cls_item.cls = CLS_UPDATE;
			default:      cls_item.cls = CLS_IGNORE;
		endcase
		if (!sym_ok) begin
			cls_item.cls = CLS_IGNORE;
		end
	end

	// queue handshake
	assign in_stall = (count_q == QCNT_W'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_item   = q_mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls_item;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_CLK(a_pop_nonempty, clk, arst_n, q_pop |-> (count_q != '0), "pop from empty queue")
	`ASSERT_CLK(a_count_bound, clk, arst_n, count_q <= QCNT_W'(QDEPTH), "queue count overflow")

endmodule

// ----- rtl/core/psl_back.sv -----
`include "assert_macros.svh"

module psl_back
	import psl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  queue_item_t q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        stop_fired,
	output logic        exit_flag,
	output logic        exit_side,
	output logic [31:0] exit_qty
);

	back_state_t               state_q;
	back_state_t               state_nxt;
	queue_item_t               item_q;
	logic [NUM_SYMBOLS-1:0]    valid_q;

	logic                      ram_rd_en;
	logic                      ram_wr_en;
	logic [ENTRY_W-1:0]        ram_rd_data;
	entry_t                    ram_wr_data;

	entry_t                    ent;
	entry_t                    upd_entry;
	entry_t                    set_entry;
	logic                      armed;
	level_t                    p_ext;
	level_t                    new_level;
	logic                      rise;
	logic                      nonpct_fire;
	logic                      is_pct;
	logic                      pct_cond;
	logic [PRICE_BITS+15:0]    drop_calc;
	logic [PRICE_BITS+15:0]    lim_calc;

	entry_t                    upd_entry_q;
	logic                      armed_q;
	logic                      nonpct_fire_q;
	logic                      is_pct_q;
	logic                      pct_cond_q;
	logic [PRICE_BITS+15:0]    drop_q;
	logic [PRICE_BITS+15:0]    lim_q;

	logic                      fire;
	logic                      go;
	logic                      is_set;
	logic                      do_exit;

	psl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_SYMBOLS)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (item_q.idx),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (q_item.idx),
		.rd_data (ram_rd_data)
	);

	// evaluate the stop against the entry just read
	always_comb begin
		ent       = entry_t'(ram_rd_data);
		armed     = valid_q[item_q.idx] && (item_q.cls == CLS_UPDATE);
		p_ext     = {1'b0, item_q.price};
		rise      = (item_q.price > ent.peak);
		new_level = rise ? ($signed({1'b0, item_q.price}) - $signed({1'b0, ent.trail}))
			: ent.level;
		upd_entry   = ent;
		nonpct_fire = 1'b0;
		is_pct      = 1'b0;
		case (ent.kind)
			KIND_FIXED: begin
				nonpct_fire = (p_ext <= ent.level);
			end
			KIND_TRAIL: begin
				upd_entry.peak  = rise ? item_q.price : ent.peak;
				upd_entry.level = new_level;
				nonpct_fire     = (p_ext <= new_level);
			end
			KIND_PCT: begin
				is_pct = 1'b1;
			end
			default: begin
				nonpct_fire = 1'b0;
			end
		endcase
		pct_cond  = (item_q.avg != '0) && (item_q.price <= item_q.avg);
		drop_calc = {item_q.avg - item_q.price, 16'h0000};
		lim_calc  = (PRICE_BITS+16)'(ent.frac) * (PRICE_BITS+16)'(item_q.avg);
	end

	// evaluation register, splits the multiply from the compare
	always_ff @(posedge clk) begin
		if (state_q == B_EVAL) begin
			upd_entry_q   <= upd_entry;
			armed_q       <= armed;
			nonpct_fire_q <= nonpct_fire;
			is_pct_q      <= is_pct;
			pct_cond_q    <= pct_cond;
			drop_q        <= drop_calc;
			lim_q         <= lim_calc;
		end
	end

	// new entry contents for the set requests
	always_comb begin
		set_entry = '0;
		is_set    = 1'b1;
		case (item_q.cls)
			CLS_SET_FIXED: begin
				set_entry.kind  = KIND_FIXED;
				set_entry.level = {1'b0, item_q.price};
			end
			CLS_SET_TRAIL: begin
				set_entry.kind  = KIND_TRAIL;
				set_entry.trail = item_q.trail;
			end
			CLS_SET_PCT: begin
				set_entry.kind = KIND_PCT;
				set_entry.frac = item_q.frac;
			end
			default: begin
				is_set = 1'b0;
			end
		endcase
	end

	// final fire decision
	assign fire    = armed_q && (nonpct_fire_q || (is_pct_q && pct_cond_q && (drop_q >= lim_q)));
	assign do_exit = fire && item_q.exit_req;
	assign go      = !out_valid || !out_stall;

	// sequencer: next state and strobes
	always_comb begin
		state_nxt   = state_q;
		q_pop       = 1'b0;
		ram_rd_en   = 1'b0;
		ram_wr_en   = 1'b0;
		ram_wr_data = is_set ? set_entry : upd_entry_q;
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					q_pop     = 1'b1;
					ram_rd_en = 1'b1;
					state_nxt = B_EVAL;
				end
			end
			B_EVAL: begin
				state_nxt = B_DONE;
			end
			B_DONE: begin
				if (go) begin
					ram_wr_en = is_set || (armed_q && !fire);
					state_nxt = B_IDLE;
				end
			end
			default: begin
				state_nxt = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
	end

	// armed bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if ((state_q == B_DONE) && go) begin
			if (is_set) begin
				valid_q[item_q.idx] <= 1'b1;
			end else if ((item_q.cls == CLS_REMOVE) || fire) begin
				valid_q[item_q.idx] <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == B_DONE) && go) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == B_DONE) && go) begin
			stop_fired <= fire;
			exit_flag  <= do_exit;
			exit_side  <= do_exit && item_q.exit_side;
			exit_qty   <= do_exit ? item_q.exit_qty : 32'd0;
		end
	end

	`ASSERT_CLK(a_exit_needs_fire, clk, arst_n, (out_valid && exit_flag) |-> stop_fired, "exit without fire")
	`ASSERT_CLK(a_quiet_no_exit, clk, arst_n, (out_valid && !exit_flag) |-> (!exit_side && exit_qty == 32'd0), "stale exit fields")
	`ASSERT_CLK(a_wr_in_done, clk, arst_n, ram_wr_en |-> (state_q == B_DONE), "table write outside done")
	`ASSERT_NEXT(a_pop_to_eval, clk, arst_n, q_pop, state_q == B_EVAL, "pop not followed by eval")

endmodule

// ----- rtl/core/per_symbol_stop_loss_table.sv -----
// Per-symbol stop-loss table: one fixed, trailing or percentage stop per symbol, set or removed
// by requests and checked on every price update request; a firing stop clears its entry and,
// for a nonzero position, asks for an exit of the opposite side for the full size. Each request
// gets exactly one result. A front end classifies requests into a two-entry queue, so up to
// two requests are taken while the back end is busy or a result waits. The back end handles
// one request at a time: table RAM read, evaluation with a registered Q0.16 multiply, then
// compare and write-back; this read-modify-write loop must finish before the next request is
// popped from the queue, even when results are taken at once. Armed bits are flip-flops
// cleared by reset, so the table is usable right after reset with no clearing pass.
module per_symbol_stop_loss_table
	import psl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic [5:0]         symbol,
	input  logic [31:0]        price,
	input  logic [31:0]        trail_gap,
	input  logic [15:0]        loss_fraction,
	input  logic [31:0]        basis_price,
	input  logic signed [31:0] position_qty,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               stop_fired,
	output logic               exit_flag,
	output logic               exit_side,
	output logic [31:0]        exit_qty
);

	logic        q_valid;
	logic        q_pop;
	queue_item_t q_item;

	// request classification and queue
	psl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.symbol        (symbol),
		.price         (price),
		.trail_gap     (trail_gap),
		.loss_fraction (loss_fraction),
		.basis_price   (basis_price),
		.position_qty  (position_qty),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	// table update and stop evaluation
	psl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.stop_fired (stop_fired),
		.exit_flag  (exit_flag),
		.exit_side  (exit_side),
		.exit_qty   (exit_qty)
	);

endmodule

// ----- bench/stop_table_checker.sv -----
`timescale 1ns / 100ps

module stop_table_checker
	import psl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         op,
	input  logic [5:0]         symbol,
	input  logic [31:0]        price,
	input  logic [31:0]        trail_gap,
	input  logic [15:0]        loss_fraction,
	input  logic [31:0]        basis_price,
	input  logic signed [31:0] position_qty,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               stop_fired,
	input  logic               exit_flag,
	input  logic               exit_side,
	input  logic [31:0]        exit_qty,
	output int                 errors,
	output int                 pending,
	output int                 fired_count,
	output int                 exit_count
);

	typedef struct packed {
		logic        fired;
		logic        exit_req;
		logic        side;
		logic [31:0] qty;
	} stop_result_t;

	// shadow copy of the stop table
	logic        armed [NUM_SYMBOLS];
	stop_kind_t  kind [NUM_SYMBOLS];
	level_t      level [NUM_SYMBOLS];
	price_t      peak [NUM_SYMBOLS];
	price_t      trail_dist [NUM_SYMBOLS];
	logic [15:0] frac_q16 [NUM_SYMBOLS];

	// stop results still owed by the block, oldest first
	stop_result_t expected_stops [$];

	function automatic void clear_slot(input idx_t s);
		armed[s] = 1'b0;
		kind[s] = KIND_FIXED;
		level[s] = '0;
		peak[s] = '0;
		trail_dist[s] = '0;
		frac_q16[s] = '0;
	endfunction

	// apply one request to the shadow table and return the result it must give
	function automatic stop_result_t apply_stop_request(
		input logic [2:0]  req_op,
		input idx_t        s,
		input price_t      px,
		input price_t      trl,
		input logic [15:0] lf,
		input price_t      avg,
		input logic [31:0] qty
	);
		stop_result_t r;
		logic         hit;
		level_t       px_s;
		level_t       trl_s;
		logic [47:0]  drop;
		logic [47:0]  lim;
		r = '0;
		hit = 1'b0;
		px_s = {1'b0, px};
		case (req_op)
			OP_SET_FIXED: begin
				clear_slot(s);
				armed[s] = 1'b1;
				kind[s] = KIND_FIXED;
				level[s] = px_s;
			end
			OP_SET_TRAIL: begin
				clear_slot(s);
				armed[s] = 1'b1;
				kind[s] = KIND_TRAIL;
				trail_dist[s] = trl;
			end
			OP_SET_PCT: begin
				clear_slot(s);
				armed[s] = 1'b1;
				kind[s] = KIND_PCT;
				frac_q16[s] = lf;
			end
			OP_REMOVE: begin
				clear_slot(s);
			end
			OP_UPDATE: begin
				if (armed[s]) begin
					case (kind[s])
						KIND_FIXED: begin
							hit = px_s <= level[s];
						end
						KIND_TRAIL: begin
							// new high moves the peak and sets the level to it minus the trail
							if (px > peak[s]) begin
								peak[s] = px;
								trl_s = {1'b0, trail_dist[s]};
								level[s] = px_s - trl_s;
							end
							hit = px_s <= level[s];
						end
						KIND_PCT: begin
							// drop / avg >= frac / 65536, cross-multiplied
							if (avg != '0 && px <= avg) begin
								drop = {16'd0, avg - px} << 16;
								lim = {32'd0, frac_q16[s]} * {16'd0, avg};
								hit = drop >= lim;
							end
						end
						default: begin
						end
					endcase
					if (hit) begin
						r.fired = 1'b1;
						if (qty != '0) begin
							r.exit_req = 1'b1;
							r.side = qty[31];
							r.qty = qty[31] ? (32'd0 - qty) : qty;
						end
						clear_slot(s);
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
	endtask

	// predict on every accepted request, compare on every accepted result
	always @(posedge clk or negedge arst_n) begin : watch
		stop_result_t want;
		stop_result_t got;
		logic         bad;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SYMBOLS; i++)
				clear_slot(idx_t'(i));
			expected_stops.delete();
			errors <= 0;
			pending <= 0;
			fired_count <= 0;
			exit_count <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				want = apply_stop_request(op, symbol, price, trail_gap, loss_fraction,
					basis_price, position_qty);
				expected_stops.insert(expected_stops.size(), want);
			end
			if (out_valid && !out_stall) begin
				got = {stop_fired, exit_flag, exit_side, exit_qty};
				if (expected_stops.size() == 0) begin
					$display("%0t: result with no request waiting, actual fired=%0b exit=%0b",
						$time, stop_fired, exit_flag);
					errors <= errors + 1;
				end else begin
					want = expected_stops[0];
					expected_stops.delete(0);
					bad = 1'b0;
					if (got.fired !== want.fired) begin
						report_field("stop_fired", 32'(want.fired), 32'(got.fired));
						bad = 1'b1;
					end
					if (got.exit_req !== want.exit_req) begin
						report_field("exit_flag", 32'(want.exit_req), 32'(got.exit_req));
						bad = 1'b1;
					end
					if (got.side !== want.side) begin
						report_field("exit_side", 32'(want.side), 32'(got.side));
						bad = 1'b1;
					end
					if (got.qty !== want.qty) begin
						report_field("exit_qty", want.qty, got.qty);
						bad = 1'b1;
					end
					if (bad)
						errors <= errors + 1;
					if (want.fired)
						fired_count <= fired_count + 1;
					if (want.exit_req)
						exit_count <= exit_count + 1;
				end
			end
			pending <= expected_stops.size();
		end
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import psl_pkg::*;

	localparam int LONG_HOLD      = 120;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int TOTAL_REQUESTS = 800;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         op;
	logic [5:0]         symbol;
	logic [31:0]        price;
	logic [31:0]        trail_gap;
	logic [15:0]        loss_fraction;
	logic [31:0]        basis_price;
	logic signed [31:0] position_qty;
	logic               out_valid;
	logic               out_stall;
	logic               stop_fired;
	logic               exit_flag;
	logic               exit_side;
	logic [31:0]        exit_qty;

	int errors;
	int pending;
	int fired_count;
	int exit_count;
	int requests_sent = 0;
	int idle_cycles = 0;
	bit sender_idle = 1'b1;
	bit receiver_idle = 1'b1;
	bit hold_off_req = 1'b0;

	per_symbol_stop_loss_table u_top (.*);

	stop_table_checker u_checker (.*);

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: random stall bursts, quiet stretches, one long hold-off on request
	initial begin : receiver
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
				hold_off_req = 1'b0;
			end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(10, 40)) @(posedge clk);
			end else if (receiver_idle && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("[per_symbol_stop_loss_table] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// offer one request and hold it until taken, then maybe go idle
	task automatic send_request(
		input logic [2:0]  o,
		input logic [5:0]  s,
		input logic [31:0] px,
		input logic [31:0] trl,
		input logic [15:0] lf,
		input logic [31:0] avg,
		input logic [31:0] qty
	);
		op <= o;
		symbol <= s;
		price <= px;
		trail_gap <= trl;
		loss_fraction <= lf;
		basis_price <= avg;
		position_qty <= qty;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		requests_sent++;
		if (sender_idle && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// stop offering and wait for every owed result
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_qty();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return $urandom;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			4: return 32'hffff_ffff;
			default: begin
				if ($urandom_range(0, 1) == 0)
					return $urandom_range(1, 1000);
				return 32'd0 - 32'($urandom_range(1, 1000));
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_base();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return $urandom_range(500, 5000);
	endfunction

	// garbage request, any op including the unused codes
	task automatic noise_request();
		send_request(3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), $urandom, $urandom,
			16'($urandom), $urandom, $urandom);
	endtask

	// arm a stop on one symbol, then walk its price around the stop
	task automatic stop_sequence();
		logic [5:0]  s;
		logic [31:0] base;
		logic [2:0]  set_op;
		int          n;
		s = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7));
		base = pick_base();
		case ($urandom_range(0, 2))
			0: set_op = OP_SET_FIXED;
			1: set_op = OP_SET_TRAIL;
			default: set_op = OP_SET_PCT;
		endcase
		send_request(set_op, s, base - $urandom_range(0, 150), $urandom_range(0, 300),
			16'($urandom_range(0, 4000)), $urandom, $urandom);
		n = $urandom_range(1, 8);
		repeat (n) begin
			if ($urandom_range(0, 15) == 0)
				send_request(OP_REMOVE, s, $urandom, $urandom, 16'($urandom), $urandom, $urandom);
			else
				send_request(OP_UPDATE, s, base + $urandom_range(0, 600) - 300, $urandom,
					16'($urandom), base + $urandom_range(0, 200) - 100, pick_qty());
			base = base + $urandom_range(0, 100) - 50;
		end
	endtask

	task automatic random_until(input int target);
		while (requests_sent < target) begin
			if ($urandom_range(0, 9) == 0)
				noise_request();
			else
				stop_sequence();
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_UPDATE;
		symbol <= '0;
		price <= '0;
		trail_gap <= '0;
		loss_fraction <= '0;
		basis_price <= '0;
		position_qty <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unarmed symbol: update and remove do nothing
		send_request(OP_UPDATE, 6'd0, 32'd0, 32'd0, 16'd0, 32'd0, 32'd5);
		send_request(OP_REMOVE, 6'd63, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 32'hffff_ffff,
			32'hffff_ffff);
		// fixed stop at the top price, fires on equality with the largest long
		send_request(OP_SET_FIXED, 6'd0, 32'hffff_ffff, 32'd0, 16'd0, 32'd0, 32'd0);
		send_request(OP_UPDATE, 6'd0, 32'hffff_ffff, 32'd0, 16'd0, 32'd0, 32'h7fff_ffff);
		// fixed stop not reached, then replaced by a trailing stop on the same symbol
		send_request(OP_SET_FIXED, 6'd1, 32'd100, 32'd0, 16'd0, 32'd0, 32'd0);
		send_request(OP_UPDATE, 6'd1, 32'd101, 32'd0, 16'd0, 32'd0, 32'd7);
		send_request(OP_SET_TRAIL, 6'd1, 32'd0, 32'd50, 16'd0, 32'd0, 32'd0);
		send_request(OP_UPDATE, 6'd1, 32'd1000, 32'd0, 16'd0, 32'd0, 32'd3);
		// falls back to peak minus trail with the most negative short
		send_request(OP_UPDATE, 6'd1, 32'd950, 32'd0, 16'd0, 32'd0, 32'h8000_0000);
		// huge trail drives the level negative, never fires
		send_request(OP_SET_TRAIL, 6'd2, 32'd0, 32'hffff_ffff, 16'd0, 32'd0, 32'd0);
		send_request(OP_UPDATE, 6'd2, 32'd5, 32'd0, 16'd0, 32'd0, 32'd1);
		send_request(OP_UPDATE, 6'd2, 32'd0, 32'd0, 16'd0, 32'd0, 32'd1);
		// zero trail at zero price fires right away
		send_request(OP_SET_TRAIL, 6'd6, 32'd0, 32'd0, 16'd0, 32'd0, 32'd0);
		send_request(OP_UPDATE, 6'd6, 32'd0, 32'd0, 16'd0, 32'd0, 32'd9);
		// percentage: zero average, price above average, then full drop
		send_request(OP_SET_PCT, 6'd3, 32'd0, 32'd0, 16'hffff, 32'd0, 32'd0);
		send_request(OP_UPDATE, 6'd3, 32'd0, 32'd0, 16'd0, 32'd0, 32'd1);
		send_request(OP_UPDATE, 6'd3, 32'd1001, 32'd0, 16'd0, 32'd1000, 32'd1);
		send_request(OP_UPDATE, 6'd3, 32'd0, 32'd0, 16'd0, 32'hffff_ffff, 32'hffff_ffff);
		// zero fraction with zero position: fires with no exit order
		send_request(OP_SET_PCT, 6'd4, 32'd0, 32'd0, 16'd0, 32'd0, 32'd0);
		send_request(OP_UPDATE, 6'd4, 32'd5, 32'd0, 16'd0, 32'd5, 32'd0);
		// unused op codes
		for (int u = OP_UPDATE + 1; u < 8; u++)
			send_request(3'(u), 6'd5, $urandom, $urandom, 16'($urandom), $urandom, $urandom);
		// removed stop does not fire
		send_request(OP_SET_FIXED, 6'd5, 32'hffff_ffff, 32'd0, 16'd0, 32'd0, 32'd0);
		send_request(OP_REMOVE, 6'd5, 32'd0, 32'd0, 16'd0, 32'd0, 32'd0);
		send_request(OP_UPDATE, 6'd5, 32'd0, 32'd0, 16'd0, 32'd0, 32'd1);

		random_until(350);

		// long output hold-off while requests keep coming, so the input backs up
		pause_until_drained();
		hold_off_req = 1'b1;
		while (!out_stall) @(posedge clk);
		sender_idle = 1'b0;
		repeat (24) stop_sequence();
		sender_idle = 1'b1;
		pause_until_drained();

		random_until(650);

		// last stretch runs at full rate on both sides
		sender_idle = 1'b0;
		receiver_idle = 1'b0;
		random_until(TOTAL_REQUESTS);

		pause_until_drained();
		$display("covered %0d requests with all stop kinds, removes and unused ops", requests_sent);
		$display("%0d stops fired, %0d exit orders, one long output hold-off", fired_count,
			exit_count);
		if (errors == 0 && pending == 0) begin
			$display("[per_symbol_stop_loss_table] OK");
		end else begin
			$display("[per_symbol_stop_loss_table] ERROR");
		end
		$finish;
	end

endmodule
